>>> hdl/ips_pkg.sv
// Package: types, codes and constants of the ICE ping and switch scheduler.
package ips_pkg;

	localparam int unsigned MAX_CONNECTIONS = 8;
	localparam int unsigned SLOT_W = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Operation codes
	localparam logic [2:0] KIND_WRITE = 3'd0;
	localparam logic [2:0] KIND_REMOVE = 3'd1;
	localparam logic [2:0] KIND_SELECT = 3'd2;
	localparam logic [2:0] KIND_MARK = 3'd3;
	localparam logic [2:0] KIND_SORT = 3'd4;
	localparam logic [2:0] KIND_SET_SEL = 3'd5;
	// Unused codes: no state change, all-zero result
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;

	// Register indexes
	localparam logic [2:0] REG_WEAK_INT = 3'd0;
	localparam logic [2:0] REG_STRONG_INT = 3'd1;
	localparam logic [2:0] REG_STABLING_INT = 3'd2;
	localparam logic [2:0] REG_STABLE_INT = 3'd3;
	localparam logic [2:0] REG_MIN_PINGS = 3'd4;
	localparam logic [2:0] REG_MIN_RTT_GAIN = 3'd5;

	localparam logic [1:0] WS_UNRELIABLE = 2'd1;
	localparam int unsigned FLAG_WRITABLE = 0;
	localparam int unsigned FLAG_RECEIVING = 1;
	localparam int unsigned FLAG_STABLE = 2;
	localparam int unsigned FLAG_CREDS = 3;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  slot;
		logic [1:0]  wr_state;
		logic [3:0]  link_flags;
		logic [31:0] priority_req;
		logic [15:0] rtt_ms;
		logic [7:0]  pings_sent;
		logic [39:0] time_ms;
		logic [39:0] last_any_ping_ms;
		logic        controller_weak;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [2:0]  chosen_slot;
		logic [15:0] interval_ms;
	} result_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic load;      // capture item and apply table updates
		logic scan_clr;  // clear scan accumulators
		logic scan_en;   // evaluate slot scan_idx
		logic refill;    // clear pinged marks, restart ping search
		logic finish;    // compute result
		logic [SLOT_W-1:0] scan_idx;
	} ctrl_t;

	// Datapath status to the controller
	typedef struct packed {
		logic gate_ok;   // global interval passed (select)
		logic sel_hit;   // selected slot qualifies (select)
		logic any_unp;   // some unpinged pingable slot seen
	} stat_t;

endpackage

>>> hdl/ips_ctrl.sv
// Controller: sequences load, slot scans and result for each item.
module ips_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2:0]           kind,
	input  ips_pkg::stat_t       stat,
	output logic                 busy,
	output ips_pkg::ctrl_t       ctrl
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_CHECK  = 6'b000100,
		ST_SCAN2  = 6'b001000,
		ST_FINISH = 6'b010000,
		ST_PRE    = 6'b100000
	} state_t;

	state_t state_q;
	logic [ips_pkg::SLOT_W-1:0] idx_q;
	logic [2:0] kind_q;
	localparam logic [ips_pkg::SLOT_W-1:0] LAST =
		ips_pkg::SLOT_W'(ips_pkg::MAX_CONNECTIONS - 1);

	assign busy = (state_q != ST_IDLE);

	// Command decode
	always_comb begin
		ctrl = '0;
		ctrl.scan_idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				ctrl.load = start;
			end
			ST_PRE: begin
				ctrl.scan_clr = 1'b1;
			end
			ST_SCAN, ST_SCAN2: begin
				ctrl.scan_en = 1'b1;
			end
			ST_CHECK: begin
				ctrl.refill = !stat.any_unp;
				ctrl.scan_clr = 1'b1;
			end
			ST_FINISH: begin
				ctrl.finish = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			kind_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (start) begin
						kind_q <= kind;
						if (kind == ips_pkg::KIND_SELECT || kind == ips_pkg::KIND_SORT)
							state_q <= ST_PRE;
						else
							state_q <= ST_FINISH;
					end
				end
				ST_PRE: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST) begin
						idx_q <= '0;
						if (kind_q == ips_pkg::KIND_SELECT && stat.gate_ok && !stat.sel_hit)
							state_q <= ST_CHECK;
						else
							state_q <= ST_FINISH;
					end
				end
				ST_CHECK: begin
					state_q <= ST_SCAN2;
				end
				ST_SCAN2: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST) begin
						idx_q <= '0;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/ips_dp.sv
// Datapath: slot table, configuration registers and one-slot-per-cycle scan.
module ips_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ips_pkg::item_t                  item,
	input  logic                            cfg_we,
	input  logic [ips_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ips_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  ips_pkg::ctrl_t                  ctrl,
	output ips_pkg::stat_t                  stat,
	output logic                            res_valid,
	output ips_pkg::result_t                res
);

	localparam int unsigned N = ips_pkg::MAX_CONNECTIONS;
	localparam int unsigned SW = ips_pkg::SLOT_W;

	logic [15:0] weak_int_q, strong_int_q, stabling_int_q, stable_int_q, gain_q;
	logic [7:0]  min_pings_q;

	logic [N-1:0] valid_q, pinged_q;
	logic [1:0]   ws_q [N];
	logic [3:0]   fl_q [N];
	logic [31:0]  pri_q [N];
	logic [15:0]  rtt_q [N];
	logic [7:0]   pings_q [N];
	logic [39:0]  lp_q [N];
	logic         sel_v_q;
	logic [SW-1:0] sel_i_q;

	ips_pkg::item_t it_q;

	// Scan accumulators
	logic          need_more_q, any_q, have_q, sel_hit_q;
	logic [SW-1:0] top_q;

	// Per-slot evaluation of scan_idx
	logic [SW-1:0] si;
	logic [15:0]   s_int;
	logic          past, pingable_c, cand, better;
	logic [40:0]   due;
	assign si = ctrl.scan_idx;

	always_comb begin
		if (pings_q[si] < min_pings_q)
			s_int = weak_int_q;
		else if (it_q.controller_weak || !fl_q[si][ips_pkg::FLAG_STABLE])
			s_int = stabling_int_q;
		else
			s_int = stable_int_q;
		due = {1'b0, lp_q[si]} + 41'(s_int);
		past = {1'b0, it_q.time_ms} >= due;
		pingable_c = fl_q[si][ips_pkg::FLAG_CREDS] && (it_q.controller_weak || past);
		cand = valid_q[si] && !pinged_q[si] && pingable_c;
	end

	// Ranking of scan slot against current top
	always_comb begin
		if (fl_q[si][ips_pkg::FLAG_WRITABLE] != fl_q[top_q][ips_pkg::FLAG_WRITABLE])
			better = fl_q[si][ips_pkg::FLAG_WRITABLE];
		else if (ws_q[si] != ws_q[top_q])
			better = ws_q[si] < ws_q[top_q];
		else if (fl_q[si][ips_pkg::FLAG_RECEIVING] != fl_q[top_q][ips_pkg::FLAG_RECEIVING])
			better = fl_q[si][ips_pkg::FLAG_RECEIVING];
		else if (pri_q[si] != pri_q[top_q])
			better = pri_q[si] > pri_q[top_q];
		else
			better = rtt_q[si] < rtt_q[top_q];
	end

	// Selected slot check, evaluated while scanning that slot
	logic sel_here;
	assign sel_here = sel_v_q && (sel_i_q == si) && valid_q[si] &&
		fl_q[si][ips_pkg::FLAG_WRITABLE] && past;

	// Global interval gate; the slot being scanned counts in the same cycle
	logic        need_more_c;
	logic [15:0] g_int;
	logic        gate_c;
	assign need_more_c = need_more_q ||
		(ctrl.scan_en && valid_q[si] && pings_q[si] < min_pings_q);
	assign g_int = (it_q.controller_weak || need_more_c) ? weak_int_q : strong_int_q;
	assign gate_c = {1'b0, it_q.time_ms} >= ({1'b0, it_q.last_any_ping_ms} + 41'(g_int));

	assign stat.gate_ok = gate_c;
	assign stat.sel_hit = sel_hit_q || (ctrl.scan_en && sel_here);
	assign stat.any_unp = any_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weak_int_q <= 16'd48;
			strong_int_q <= 16'd480;
			stabling_int_q <= 16'd900;
			stable_int_q <= 16'd2500;
			min_pings_q <= 8'd3;
			gain_q <= 16'd10;
		end else if (cfg_we) begin
			case (cfg_idx)
				ips_pkg::REG_WEAK_INT:     weak_int_q <= cfg_data;
				ips_pkg::REG_STRONG_INT:   strong_int_q <= cfg_data;
				ips_pkg::REG_STABLING_INT: stabling_int_q <= cfg_data;
				ips_pkg::REG_STABLE_INT:   stable_int_q <= cfg_data;
				ips_pkg::REG_MIN_PINGS:    min_pings_q <= cfg_data[7:0];
				ips_pkg::REG_MIN_RTT_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Slot attributes (no reset)
	always_ff @(posedge clk) begin
		if (ctrl.load) it_q <= item;
		if (ctrl.load && item.kind == ips_pkg::KIND_WRITE) begin
			ws_q[item.slot] <= item.wr_state;
			fl_q[item.slot] <= item.link_flags;
			pri_q[item.slot] <= item.priority_req;
			rtt_q[item.slot] <= item.rtt_ms;
			pings_q[item.slot] <= item.pings_sent;
			lp_q[item.slot] <= item.time_ms;
		end
	end

	// Valid, pinged and selection state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pinged_q <= '0;
			sel_v_q <= 1'b0;
			sel_i_q <= '0;
		end else if (ctrl.load) begin
			case (item.kind)
				ips_pkg::KIND_WRITE: begin
					if (!valid_q[item.slot]) pinged_q[item.slot] <= 1'b0;
					valid_q[item.slot] <= 1'b1;
				end
				ips_pkg::KIND_REMOVE: begin
					valid_q[item.slot] <= 1'b0;
					pinged_q[item.slot] <= 1'b0;
					if (sel_v_q && sel_i_q == item.slot) sel_v_q <= 1'b0;
				end
				ips_pkg::KIND_MARK: begin
					if (valid_q[item.slot]) pinged_q[item.slot] <= 1'b1;
				end
				ips_pkg::KIND_SET_SEL: begin
					sel_v_q <= valid_q[item.slot];
					sel_i_q <= valid_q[item.slot] ? item.slot : '0;
				end
				default: ;
			endcase
		end else if (ctrl.refill) begin
			pinged_q <= '0;
		end
	end

	// Scan accumulators
	always_ff @(posedge clk) begin
		if (ctrl.scan_clr) begin
			any_q <= 1'b0;
			have_q <= 1'b0;
			top_q <= '0;
			if (!ctrl.refill) begin
				need_more_q <= 1'b0;
				sel_hit_q <= 1'b0;
			end
		end else if (ctrl.scan_en) begin
			if (valid_q[si] && pings_q[si] < min_pings_q) need_more_q <= 1'b1;
			if (sel_here) sel_hit_q <= 1'b1;
			if (cand) any_q <= 1'b1;
			if (it_q.kind == ips_pkg::KIND_SORT) begin
				if (valid_q[si] && (!have_q || better)) begin
					top_q <= si;
					have_q <= 1'b1;
				end
			end else if (cand && (!have_q || lp_q[si] < lp_q[top_q])) begin
				top_q <= si;
				have_q <= 1'b1;
			end
		end
	end

	// Result formation
	logic        sw_ok;
	logic [16:0] rtt_sum;
	ips_pkg::result_t res_c;
	assign rtt_sum = {1'b0, rtt_q[top_q]} + {1'b0, gain_q};
	always_comb begin
		sw_ok = have_q &&
			(fl_q[top_q][ips_pkg::FLAG_WRITABLE] || ws_q[top_q] == ips_pkg::WS_UNRELIABLE) &&
			!(sel_v_q && sel_i_q == top_q) &&
			(!sel_v_q || !valid_q[sel_i_q] || rtt_sum <= {1'b0, rtt_q[sel_i_q]});
	end

	always_comb begin
		res_c = '0;
		case (it_q.kind)
			ips_pkg::KIND_SELECT: begin
				res_c.interval_ms = g_int;
				if (gate_c) begin
					if (sel_hit_q) begin
						res_c.found = 1'b1;
						res_c.chosen_slot = sel_i_q;
					end else if (have_q) begin
						res_c.found = 1'b1;
						res_c.chosen_slot = top_q;
					end
				end
			end
			ips_pkg::KIND_SORT: begin
				if (sw_ok) begin
					res_c.found = 1'b1;
					res_c.chosen_slot = top_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= ctrl.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) res <= res_c;
	end

endmodule

>>> hdl/ice_ping_and_switch_scheduler.sv
// Top level of the ICE ping and switch scheduler.
//   channel  direction  handshake             payload
//   item     in         start & !busy         item (item_t)
//   result   out        done (one cycle)      result (result_t)
//   config   in         cfg_we                cfg_index, cfg_data
// Write, remove, mark, set-selected and unused kinds go from idle straight to the
// finish state. Sort-switch and select clear the scan state, then scan every slot
// before finish; select scans a second time when the unpinged set is searched
// (a second pass of one slot per cycle after a possible refill).
// busy falls as done rises, so the next item can go on the result's edge.
// Reset clears valid and pinged marks, selection and loads register defaults.
// The receiver cannot stall; busy holds off the next item.
module ice_ping_and_switch_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  ips_pkg::item_t                  item,
	output logic                            busy,
	output logic                            done,
	output ips_pkg::result_t                result,
	input  logic                            cfg_we,
	input  logic [ips_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ips_pkg::CFG_DATA_W-1:0]  cfg_data
);

	ips_pkg::ctrl_t ctrl;
	ips_pkg::stat_t stat;

	ips_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(item.kind),
		.stat(stat), .busy(busy), .ctrl(ctrl)
	);

	ips_dp u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .cfg_we(cfg_we),
		.cfg_idx(cfg_index), .cfg_data(cfg_data), .ctrl(ctrl), .stat(stat),
		.res_valid(done), .res(result)
	);

endmodule
